/* rtl/core/pmrc_pkg.sv */
// ----------------------------------------------------------------------------
// pmrc_pkg
// Shared types, constants and the CRC-8 byte update for the PMBus read checker.
// ----------------------------------------------------------------------------
package pmrc_pkg;

  localparam int unsigned CfgAddrWidth = 1;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned InDataWidth  = 16;  // command_code, byte_value
  localparam int unsigned InUserWidth  = 2;   // data_format
  localparam int unsigned OutDataWidth = 88;  // 82 payload bits, zero filled
  localparam int unsigned ValueWidth   = 48;

  localparam logic [7:0] CrcPoly = 8'h07;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_MODE_BYTE      = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    FMT_LINEAR11 = 2'd0,
    FMT_LINEAR16 = 2'd1,
    FMT_RAW_BYTE = 2'd2,
    FMT_SPARE    = 2'd3
  } data_format_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PEC_BAD  = 2'd1,
    STATUS_MODE_BAD = 2'd2
  } status_t;

  // What the frame tracker shows for the byte now at the head of the pipe.
  typedef struct packed {
    logic [7:0]  crc;       // running CRC before this byte
    logic [15:0] raw_word;  // {data_high, data_low}
  } frame_t;

  // One serial CRC-8 byte step, MSB first, init handled by caller.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ CrcPoly) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

endpackage

/* rtl/core/pmbus_read_check_decode.sv */
// ----------------------------------------------------------------------------
// pmbus_read_check_decode
// PMBus read-response PEC checker and value decoder, one byte per word.
// ----------------------------------------------------------------------------
// Feed the bytes of a read response in order, one per input word; the word
// carrying tlast is the PEC byte and yields exactly one result word, other
// words yield none. The first word of each response seeds the CRC-8 (poly
// 0x07) with the write address, its command_code and the read address. The
// result holds status (ok / PEC mismatch / unsupported output mode), both
// PEC bytes, the raw little-endian data word and the decoded value as signed
// fixed point with 16 fraction bits; value is zero unless status is ok.
// Throughput is one byte per clock while no PEC byte waits on a stalled
// result: the input register feeds combinational CRC and barrel-shift logic
// into the result register as the PEC byte moves on. A stalled result only
// holds the input stage when the word at its head is a PEC byte. Write
// device_address and the output-mode byte only while no response is in flight.
// ----------------------------------------------------------------------------
module pmbus_read_check_decode (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [pmrc_pkg::CfgAddrWidth-1:0]   cfg_addr,
  input  logic [pmrc_pkg::CfgDataWidth-1:0]   cfg_data,
  // byte stream in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pmrc_pkg::InDataWidth-1:0]    s_tdata,   // [7:0] command_code, [15:8] byte_value
  input  logic [pmrc_pkg::InUserWidth-1:0]    s_tuser,   // [1:0] data_format
  input  logic                                s_tlast,   // last_byte (PEC byte)
  // result stream out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pmrc_pkg::OutDataWidth-1:0]   m_tdata    // [1:0] status, [9:2] expected_pec,
                                                         // [17:10] received_pec,
                                                         // [33:18] raw_word,
                                                         // [81:34] value_fixed, rest zero
);
  import pmrc_pkg::*;

  // config registers
  logic [6:0] device_address;
  logic [7:0] mode_byte;

  // input register
  logic       in_valid;
  logic [7:0] in_command_code;
  logic [1:0] in_data_format;
  logic [7:0] in_byte_value;
  logic       in_last_byte;

  // result register
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [7:0]            out_expected_pec;
  logic [7:0]            out_received_pec;
  logic [15:0]           out_raw_word;
  logic [ValueWidth-1:0] out_value_fixed;

  logic                  out_free;
  logic                  advance;
  frame_t                frame;
  logic [1:0]            dec_status;
  logic signed [ValueWidth-1:0] dec_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 7'd0;
      mode_byte      <= 8'd0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        REG_MODE_BYTE:      mode_byte      <= cfg_data;
        default: ;
      endcase
    end
  end

  // data bytes never wait on the output; PEC bytes need a free result slot
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && (!in_last_byte || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_command_code <= s_tdata[7:0];
      in_byte_value   <= s_tdata[15:8];
      in_data_format  <= s_tuser;
      in_last_byte    <= s_tlast;
    end
  end

  pmrc_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .device_address (device_address),
    .command_code   (in_command_code),
    .byte_value     (in_byte_value),
    .last_byte      (in_last_byte),
    .frame          (frame)
  );

  pmrc_decode u_decode (
    .frame          (frame),
    .data_format    (in_data_format),
    .received_pec   (in_byte_value),
    .mode_byte      (mode_byte),
    .status         (dec_status),
    .value_fixed    (dec_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last_byte) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_byte) begin
      out_status       <= dec_status;
      out_expected_pec <= frame.crc;
      out_received_pec <= in_byte_value;
      out_raw_word     <= frame.raw_word;
      out_value_fixed  <= dec_value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_value_fixed, out_raw_word, out_received_pec,
                     out_expected_pec, out_status};

endmodule

/* rtl/core/pmrc_frame.sv */
// ----------------------------------------------------------------------------
// pmrc_frame
// Response tracker: address/command seed, running CRC and stored data bytes.
// ----------------------------------------------------------------------------
module pmrc_frame (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,          // head word consumed this cycle
  input  logic [6:0]      device_address,
  input  logic [7:0]      command_code,
  input  logic [7:0]      byte_value,
  input  logic            last_byte,
  output pmrc_pkg::frame_t frame
);
  import pmrc_pkg::*;

  logic       in_response;
  logic [7:0] running_crc;
  logic [1:0] byte_index;
  logic [7:0] data_low;
  logic [7:0] data_high;

  logic [7:0] write_addr;
  logic [7:0] seed;
  logic [7:0] crc_cur;
  logic [1:0] idx_cur;
  logic [7:0] lo_cur;
  logic [7:0] hi_cur;

  // A new response starts from a fresh seed and cleared data bytes.
  always_comb begin
    write_addr = {device_address, 1'b0};
    seed       = crc8_byte(crc8_byte(crc8_byte(8'h00, write_addr), command_code),
                           write_addr | 8'h01);
    crc_cur    = in_response ? running_crc : seed;
    idx_cur    = in_response ? byte_index  : 2'd0;
    lo_cur     = in_response ? data_low    : 8'h00;
    hi_cur     = in_response ? data_high   : 8'h00;
  end

  assign frame.crc      = crc_cur;
  assign frame.raw_word = {hi_cur, lo_cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_response <= 1'b0;
      running_crc <= 8'h00;
      byte_index  <= 2'd0;
      data_low    <= 8'h00;
      data_high   <= 8'h00;
    end else if (step) begin
      if (last_byte) begin
        in_response <= 1'b0;
        byte_index  <= 2'd0;
      end else begin
        in_response <= 1'b1;
        running_crc <= crc8_byte(crc_cur, byte_value);
        data_low    <= (idx_cur == 2'd0) ? byte_value : lo_cur;
        data_high   <= (idx_cur == 2'd1) ? byte_value : hi_cur;
        byte_index  <= (idx_cur == 2'd3) ? idx_cur : idx_cur + 2'd1;
      end
    end
  end

endmodule

/* rtl/core/pmrc_decode.sv */
// ----------------------------------------------------------------------------
// pmrc_decode
// PEC compare and LINEAR11 / LINEAR16 / raw decode into 16-fraction-bit fixed.
// ----------------------------------------------------------------------------
module pmrc_decode (
  input  pmrc_pkg::frame_t                    frame,
  input  logic [1:0]                          data_format,
  input  logic [7:0]                          received_pec,
  input  logic [7:0]                          mode_byte,
  output logic [1:0]                          status,
  output logic signed [pmrc_pkg::ValueWidth-1:0] value_fixed
);
  import pmrc_pkg::*;

  logic [ValueWidth-1:0] operand;
  logic [4:0]            exponent;
  logic [4:0]            shamt;
  status_t               st;

  always_comb begin
    case (data_format_t'(data_format))
      FMT_LINEAR11: begin
        operand  = {{(ValueWidth-11){frame.raw_word[10]}}, frame.raw_word[10:0]};
        exponent = frame.raw_word[15:11];
      end
      FMT_LINEAR16: begin
        operand  = {{(ValueWidth-16){1'b0}}, frame.raw_word};
        exponent = mode_byte[4:0];
      end
      default: begin
        operand  = {{(ValueWidth-8){1'b0}}, frame.raw_word[7:0]};
        exponent = 5'd0;
      end
    endcase
    // 16 + signed exponent, range 0..31: flip the sign bit.
    shamt = {~exponent[4], exponent[3:0]};

    if (frame.crc != received_pec) begin
      st = STATUS_PEC_BAD;
    end else if (data_format == FMT_LINEAR16 && mode_byte[7:5] != 3'd0) begin
      st = STATUS_MODE_BAD;
    end else begin
      st = STATUS_OK;
    end
  end

  assign status      = st;
  assign value_fixed = (st == STATUS_OK) ? signed'(operand << shamt) : '0;

endmodule
